// ===== rtl/tcp_opt_pkg.sv =====
// ----------------------------------------------------------------------------
// tcp_opt_pkg
// Shared types and codes for the TCP option area parser.
// ----------------------------------------------------------------------------
package tcp_opt_pkg;

  // record types
  localparam logic [1:0] REC_DATA   = 2'd0;
  localparam logic [1:0] REC_OPTION = 2'd1;
  localparam logic [1:0] REC_END    = 2'd2;

  // option status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEN  = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;
  localparam logic [1:0] ST_ZERO_LEN = 2'd3;

  // option kinds with special handling
  localparam logic [7:0] KIND_EOL    = 8'd0;
  localparam logic [7:0] KIND_NOP    = 8'd1;
  localparam logic [7:0] KIND_MSS    = 8'd2;
  localparam logic [7:0] KIND_WSCALE = 8'd3;
  localparam logic [7:0] KIND_TS     = 8'd8;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  // everything one input byte produces: up to a data, an option and an end record
  typedef struct packed {
    logic        has_data;
    logic        has_opt;
    logic        has_end;
    logic [7:0]  kind;
    logic [7:0]  length;
    logic [1:0]  status;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic [7:0]  data_byte;
    logic [5:0]  data_index;
  } bundle_t;

  // queue handshake between modules
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/tcp_opt_ifs.sv =====
// ----------------------------------------------------------------------------
// tcp_opt channels
// Valid/ready channel bundles for option bytes in and parser records out.
// ----------------------------------------------------------------------------
interface tcp_opt_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [5:0] area_len;
  logic [7:0] opt_byte;

  modport source (output valid, start_req, area_len, opt_byte, input ready);
  modport sink   (input valid, start_req, area_len, opt_byte, output ready);
endinterface

interface tcp_opt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  rec_type;
  logic [7:0]  opt_kind;
  logic [7:0]  opt_length;
  logic [1:0]  status;
  logic [31:0] value_a;
  logic [31:0] value_b;
  logic [7:0]  data_byte;
  logic [5:0]  data_index;
  logic        last;

  modport source (output valid, rec_type, opt_kind, opt_length, status, value_a,
                  value_b, data_byte, data_index, last, input ready);
  modport sink   (input valid, rec_type, opt_kind, opt_length, status, value_a,
                  value_b, data_byte, data_index, last, output ready);
endinterface

// ===== rtl/tcp_option_parser.sv =====
// ----------------------------------------------------------------------------
// tcp_option_parser
// Streaming TCP header option parser: one option byte in, typed records out.
// ----------------------------------------------------------------------------
// The block takes one option byte per transfer, every cycle, as long as its
// four-entry record queue has room. A byte with start_req opens a new area
// (length clamped to MAX_OPT_BYTES) and is itself the first byte of it. Each
// byte yields zero to three records: a data record for every option data
// byte, an option record per option (kind, length, status, decoded MSS,
// window scale or timestamp values) and an end-of-list record closing the
// area; last marks the final record of each byte. The output side moves one
// record per cycle while rec_out.ready is high, so a byte with two or three
// records holds the output for one transfer each; the queue absorbs bursts
// as the input keeps flowing. A byte's records pass through the queue and
// the cur register. Bytes outside an open area or after EOL yield nothing.
// ----------------------------------------------------------------------------
module tcp_option_parser #(
  parameter int MAX_OPT_BYTES = 40
) (
  input  logic          clk,
  input  logic          rst,
  tcp_opt_in_if.sink    opt_in,
  tcp_opt_out_if.source rec_out
);

  // front side: parser state machine
  logic                   accept;
  logic                   q_push;
  logic                   q_pop;
  tcp_opt_pkg::bundle_t   push_data;
  tcp_opt_pkg::bundle_t   q_head;
  tcp_opt_pkg::q_status_t q_stat;

  // take a byte whenever the queue can hold its records
  assign opt_in.ready = !q_stat.full;
  assign accept       = opt_in.valid && opt_in.ready;

  tcp_opt_front #(
    .MAX_OPT_BYTES (MAX_OPT_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .start_req (opt_in.start_req),
    .area_len  (opt_in.area_len),
    .opt_byte  (opt_in.opt_byte),
    .push      (q_push),
    .bundle    (push_data)
  );

  // decoupling queue
  tcp_opt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .q_stat    (q_stat),
    .head      (q_head)
  );

  // back side: record serializer
  tcp_opt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_stat  (q_stat),
    .head    (q_head),
    .pop     (q_pop),
    .rec_out (rec_out)
  );

`ifndef SYNTH
  // never write into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("record queue overflow");

  // queued records reach the output by the next cycle
  a_drain: assert property (@(posedge clk) disable iff (rst)
    !q_stat.empty |=> rec_out.valid)
    else $error("queued records not presented");

  // end-of-list record always closes its byte's records
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (rec_out.valid && rec_out.rec_type == tcp_opt_pkg::REC_END) |-> rec_out.last)
    else $error("end record without last");
`endif

endmodule

// ===== rtl/tcp_opt_front.sv =====
// ----------------------------------------------------------------------------
// tcp_opt_front
// Per-byte option parser state machine; packs the records of one byte.
// ----------------------------------------------------------------------------
module tcp_opt_front #(
  parameter int MAX_OPT_BYTES = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 start_req,
  input  logic [5:0]           area_len,
  input  logic [7:0]           opt_byte,
  output logic                 push,
  output tcp_opt_pkg::bundle_t bundle
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_KIND = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  localparam logic [5:0] MAX_LEN = 6'(MAX_OPT_BYTES);

  logic [1:0]  phase, phase_next;
  logic [5:0]  bytes_left, bytes_left_next;
  logic [7:0]  cur_kind, cur_kind_next;
  logic [7:0]  cur_length, cur_length_next;
  logic [5:0]  data_count, data_count_next;
  logic [63:0] value_shift, value_shift_next;

  logic [1:0]  eph;
  logic [5:0]  ebl, clamped, bl_dec;
  logic [7:0]  ekind, elen, dlen;
  logic [5:0]  edc;
  logic [63:0] evs;
  logic        do_after, use_decode;
  logic [1:0]  after_phase, forced_st;
  logic        has_data, has_opt, has_end;
  logic [1:0]  st;
  logic [31:0] va, vb;

  always_comb begin
    clamped = (area_len > MAX_LEN) ? MAX_LEN : area_len;
    eph   = phase;
    ebl   = bytes_left;
    ekind = cur_kind;
    elen  = cur_length;
    edc   = data_count;
    evs   = value_shift;
    if (start_req) begin
      eph   = (clamped == 6'd0) ? PH_IDLE : PH_KIND;
      ebl   = clamped;
      ekind = 8'd0;
      elen  = 8'd0;
      edc   = 6'd0;
      evs   = 64'd0;
    end

    phase_next       = eph;
    bytes_left_next  = ebl;
    cur_kind_next    = ekind;
    cur_length_next  = elen;
    data_count_next  = edc;
    value_shift_next = evs;
    has_data    = 1'b0;
    has_opt     = 1'b0;
    has_end     = 1'b0;
    do_after    = 1'b0;
    after_phase = PH_KIND;
    use_decode  = 1'b0;
    forced_st   = tcp_opt_pkg::ST_OK;
    bl_dec      = ebl - 6'd1;

    if (start_req && clamped == 6'd0) begin
      has_end = 1'b1;
    end else begin
      case (eph)
        PH_KIND: begin
          if (opt_byte == tcp_opt_pkg::KIND_EOL) begin
            has_end         = 1'b1;
            phase_next      = PH_IDLE;
            bytes_left_next = 6'd0;
          end else if (opt_byte == tcp_opt_pkg::KIND_NOP) begin
            cur_kind_next   = tcp_opt_pkg::KIND_NOP;
            cur_length_next = 8'd1;
            has_opt         = 1'b1;
            do_after        = 1'b1;
            after_phase     = PH_KIND;
          end else if (ebl <= 6'd1) begin
            // lone kind byte at the end of the area
            has_end         = 1'b1;
            phase_next      = PH_IDLE;
            bytes_left_next = 6'd0;
          end else begin
            cur_kind_next   = opt_byte;
            cur_length_next = 8'd0;
            do_after        = 1'b1;
            after_phase     = PH_LEN;
          end
        end
        PH_LEN: begin
          cur_length_next = opt_byte;
          if (opt_byte == 8'd0) begin
            has_opt         = 1'b1;
            forced_st       = tcp_opt_pkg::ST_ZERO_LEN;
            has_end         = 1'b1;
            phase_next      = PH_IDLE;
            bytes_left_next = 6'd0;
          end else if (opt_byte > ({2'b00, ebl} + 8'd1)) begin
            has_opt         = 1'b1;
            forced_st       = tcp_opt_pkg::ST_TRUNC;
            has_end         = 1'b1;
            phase_next      = PH_IDLE;
            bytes_left_next = 6'd0;
          end else if (opt_byte == 8'd1) begin
            has_opt     = 1'b1;
            forced_st   = tcp_opt_pkg::ST_BAD_LEN;
            do_after    = 1'b1;
            after_phase = PH_KIND;
          end else if (opt_byte == 8'd2) begin
            value_shift_next = 64'd0;
            has_opt          = 1'b1;
            use_decode       = 1'b1;
            do_after         = 1'b1;
            after_phase      = PH_KIND;
          end else begin
            data_count_next  = 6'd0;
            value_shift_next = 64'd0;
            do_after         = 1'b1;
            after_phase      = PH_DATA;
          end
        end
        PH_DATA: begin
          has_data         = 1'b1;
          value_shift_next = {evs[55:0], opt_byte};
          data_count_next  = edc + 6'd1;
          do_after         = 1'b1;
          if (({2'b00, data_count_next} + 8'd2) >= elen) begin
            has_opt     = 1'b1;
            use_decode  = 1'b1;
            after_phase = PH_KIND;
          end else begin
            after_phase = PH_DATA;
          end
        end
        default: begin
        end
      endcase

      if (do_after) begin
        bytes_left_next = bl_dec;
        if (bl_dec == 6'd0) begin
          has_end    = 1'b1;
          phase_next = PH_IDLE;
        end else begin
          phase_next = after_phase;
        end
      end
    end

    // option value decode on the updated state
    dlen = cur_length_next - 8'd2;
    st   = forced_st;
    va   = 32'd0;
    vb   = 32'd0;
    if (use_decode) begin
      case (cur_kind_next)
        tcp_opt_pkg::KIND_MSS: begin
          if (dlen != 8'd2) st = tcp_opt_pkg::ST_BAD_LEN;
          else va = {16'd0, value_shift_next[15:0]};
        end
        tcp_opt_pkg::KIND_WSCALE: begin
          if (dlen != 8'd1) st = tcp_opt_pkg::ST_BAD_LEN;
          else va = {24'd0, value_shift_next[7:0]};
        end
        tcp_opt_pkg::KIND_TS: begin
          if (dlen != 8'd8) begin
            st = tcp_opt_pkg::ST_BAD_LEN;
          end else begin
            va = value_shift_next[63:32];
            vb = value_shift_next[31:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign push = accept && (has_data || has_opt || has_end);

  always_comb begin
    bundle.has_data   = has_data;
    bundle.has_opt    = has_opt;
    bundle.has_end    = has_end;
    bundle.kind       = cur_kind_next;
    bundle.length     = cur_length_next;
    bundle.status     = st;
    bundle.value_a    = va;
    bundle.value_b    = vb;
    bundle.data_byte  = opt_byte;
    bundle.data_index = edc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bytes_left  <= 6'd0;
      cur_kind    <= 8'd0;
      cur_length  <= 8'd0;
      data_count  <= 6'd0;
      value_shift <= 64'd0;
    end else if (accept) begin
      phase       <= phase_next;
      bytes_left  <= bytes_left_next;
      cur_kind    <= cur_kind_next;
      cur_length  <= cur_length_next;
      data_count  <= data_count_next;
      value_shift <= value_shift_next;
    end
  end

endmodule

// ===== rtl/tcp_opt_queue.sv =====
// ----------------------------------------------------------------------------
// tcp_opt_queue
// Small register FIFO of record bundles between front and back.
// ----------------------------------------------------------------------------
module tcp_opt_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  tcp_opt_pkg::bundle_t   push_data,
  input  logic                   pop,
  output tcp_opt_pkg::q_status_t q_stat,
  output tcp_opt_pkg::bundle_t   head
);

  tcp_opt_pkg::bundle_t entries [tcp_opt_pkg::QDEPTH];

  logic [tcp_opt_pkg::PTR_W-1:0] wr_ptr, rd_ptr;
  logic [tcp_opt_pkg::CNT_W-1:0] count;

  assign q_stat.full  = (count == tcp_opt_pkg::CNT_W'(tcp_opt_pkg::QDEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + tcp_opt_pkg::PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + tcp_opt_pkg::PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + tcp_opt_pkg::CNT_W'(1);
        2'b01:   count <= count - tcp_opt_pkg::CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/tcp_opt_back.sv =====
// ----------------------------------------------------------------------------
// tcp_opt_back
// Unpacks one bundle into its data, option and end records, one per transfer.
// ----------------------------------------------------------------------------
module tcp_opt_back (
  input  logic                   clk,
  input  logic                   rst,
  input  tcp_opt_pkg::q_status_t q_stat,
  input  tcp_opt_pkg::bundle_t   head,
  output logic                   pop,
  tcp_opt_out_if.source          rec_out
);

  tcp_opt_pkg::bundle_t cur;
  logic [2:0] pend;     // [0] data, [1] option, [2] end
  logic       is_last;
  logic       xfer;

  assign is_last = ((pend & (pend - 3'd1)) == 3'd0);
  assign xfer    = rec_out.valid && rec_out.ready;
  assign pop     = !q_stat.empty && ((pend == 3'd0) || (is_last && rec_out.ready));

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 3'd0;
    end else if (pop) begin
      pend <= {head.has_end, head.has_opt, head.has_data};
    end else if (xfer) begin
      pend <= pend & (pend - 3'd1);
    end
  end

  always_comb begin
    rec_out.valid      = (pend != 3'd0);
    rec_out.last       = is_last;
    rec_out.rec_type   = tcp_opt_pkg::REC_END;
    rec_out.opt_kind   = 8'd0;
    rec_out.opt_length = 8'd0;
    rec_out.status     = tcp_opt_pkg::ST_OK;
    rec_out.value_a    = 32'd0;
    rec_out.value_b    = 32'd0;
    rec_out.data_byte  = 8'd0;
    rec_out.data_index = 6'd0;
    if (pend[0]) begin
      rec_out.rec_type   = tcp_opt_pkg::REC_DATA;
      rec_out.opt_kind   = cur.kind;
      rec_out.opt_length = cur.length;
      rec_out.data_byte  = cur.data_byte;
      rec_out.data_index = cur.data_index;
    end else if (pend[1]) begin
      rec_out.rec_type   = tcp_opt_pkg::REC_OPTION;
      rec_out.opt_kind   = cur.kind;
      rec_out.opt_length = cur.length;
      rec_out.status     = cur.status;
      rec_out.value_a    = cur.value_a;
      rec_out.value_b    = cur.value_b;
    end
  end

endmodule

// ===== tb/tcp_opt_checker.sv =====
// ----------------------------------------------------------------------------
// tcp_opt_checker
// Watches both channels of the option parser, keeps its own model of the
// parse state, and compares every record with the oldest one still due.
// ----------------------------------------------------------------------------
module tcp_opt_checker #(
  parameter int MAX_OPT_BYTES = 40
) (
  input  logic   clk,
  input  logic   rst,
  tcp_opt_in_if  in_mon,
  tcp_opt_out_if out_mon,
  output int     fail_count,
  output int     records_due,
  output int     data_seen,
  output int     opts_seen,
  output int     ends_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_KIND,
    PH_LEN,
    PH_DATA
  } parse_phase_e;

  typedef struct packed {
    logic [1:0]  rec_type;
    logic [7:0]  kind;
    logic [7:0]  length;
    logic [1:0]  status;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic [7:0]  data_byte;
    logic [5:0]  data_index;
    logic        last;
  } opt_rec_t;

  opt_rec_t     due_recs[$];
  parse_phase_e phase;
  logic [5:0]   bytes_left;
  logic [7:0]   cur_kind;
  logic [7:0]   cur_length;
  logic [5:0]   data_count;
  logic [63:0]  value_sr;

  function automatic void push_rec(logic [1:0] t, logic [7:0] k, logic [7:0] l,
                                   logic [1:0] s, logic [31:0] va, logic [31:0] vb,
                                   logic [7:0] db, logic [5:0] di);
    opt_rec_t r;
    r = '{rec_type: t, kind: k, length: l, status: s, value_a: va, value_b: vb,
          data_byte: db, data_index: di, last: 1'b0};
    due_recs.push_back(r);
  endfunction

  function automatic void close_area();
    push_rec(tcp_opt_pkg::REC_END, 8'd0, 8'd0, tcp_opt_pkg::ST_OK, 32'd0, 32'd0,
             8'd0, 6'd0);
    phase      = PH_IDLE;
    bytes_left = '0;
  endfunction

  // option record with the decoded values of the three known kinds
  function automatic void push_option();
    logic [7:0]  dlen;
    logic [1:0]  st;
    logic [31:0] va;
    logic [31:0] vb;
    dlen = cur_length - 8'd2;
    st   = tcp_opt_pkg::ST_OK;
    va   = '0;
    vb   = '0;
    if (cur_kind == tcp_opt_pkg::KIND_MSS) begin
      if (dlen != 8'd2) st = tcp_opt_pkg::ST_BAD_LEN;
      else va = {16'd0, value_sr[15:0]};
    end else if (cur_kind == tcp_opt_pkg::KIND_WSCALE) begin
      if (dlen != 8'd1) st = tcp_opt_pkg::ST_BAD_LEN;
      else va = {24'd0, value_sr[7:0]};
    end else if (cur_kind == tcp_opt_pkg::KIND_TS) begin
      if (dlen != 8'd8) st = tcp_opt_pkg::ST_BAD_LEN;
      else begin
        va = value_sr[63:32];
        vb = value_sr[31:0];
      end
    end
    push_rec(tcp_opt_pkg::REC_OPTION, cur_kind, cur_length, st, va, vb, 8'd0, 6'd0);
  endfunction

  // one area byte used up; the area closes when none is left
  function automatic void consume(parse_phase_e next_phase);
    bytes_left = bytes_left - 6'd1;
    if (bytes_left == 6'd0) close_area();
    else phase = next_phase;
  endfunction

  function automatic void parse_byte(logic st, logic [5:0] alen, logic [7:0] b);
    int       n_before;
    opt_rec_t r;
    n_before = due_recs.size();
    if (st) begin
      cur_kind   = '0;
      cur_length = '0;
      data_count = '0;
      value_sr   = '0;
      bytes_left = (int'(alen) > MAX_OPT_BYTES) ? 6'(MAX_OPT_BYTES) : alen;
      if (bytes_left == 6'd0) close_area();
      else phase = PH_KIND;
    end
    if (!(st && bytes_left == 6'd0 && phase == PH_IDLE)) begin
      case (phase)
        PH_KIND: begin
          if (b == tcp_opt_pkg::KIND_EOL) begin
            close_area();
          end else if (b == tcp_opt_pkg::KIND_NOP) begin
            cur_kind   = tcp_opt_pkg::KIND_NOP;
            cur_length = 8'd1;
            push_rec(tcp_opt_pkg::REC_OPTION, tcp_opt_pkg::KIND_NOP, 8'd1,
                     tcp_opt_pkg::ST_OK, 32'd0, 32'd0, 8'd0, 6'd0);
            consume(PH_KIND);
          end else if (bytes_left <= 6'd1) begin
            close_area();
          end else begin
            cur_kind   = b;
            cur_length = 8'd0;
            consume(PH_LEN);
          end
        end
        PH_LEN: begin
          cur_length = b;
          if (b == 8'd0) begin
            push_rec(tcp_opt_pkg::REC_OPTION, cur_kind, 8'd0,
                     tcp_opt_pkg::ST_ZERO_LEN, 32'd0, 32'd0, 8'd0, 6'd0);
            close_area();
          end else if (int'(b) > int'(bytes_left) + 1) begin
            push_rec(tcp_opt_pkg::REC_OPTION, cur_kind, b,
                     tcp_opt_pkg::ST_TRUNC, 32'd0, 32'd0, 8'd0, 6'd0);
            close_area();
          end else if (b == 8'd1) begin
            push_rec(tcp_opt_pkg::REC_OPTION, cur_kind, 8'd1,
                     tcp_opt_pkg::ST_BAD_LEN, 32'd0, 32'd0, 8'd0, 6'd0);
            consume(PH_KIND);
          end else if (b == 8'd2) begin
            value_sr = '0;
            push_option();
            consume(PH_KIND);
          end else begin
            data_count = '0;
            value_sr   = '0;
            consume(PH_DATA);
          end
        end
        PH_DATA: begin
          push_rec(tcp_opt_pkg::REC_DATA, cur_kind, cur_length, tcp_opt_pkg::ST_OK,
                   32'd0, 32'd0, b, data_count);
          value_sr   = {value_sr[55:0], b};
          data_count = data_count + 6'd1;
          if (int'(data_count) + 2 >= int'(cur_length)) begin
            push_option();
            consume(PH_KIND);
          end else begin
            consume(PH_DATA);
          end
        end
        default: ;
      endcase
    end
    if (due_recs.size() > n_before) begin
      r = due_recs.pop_back();
      r.last = 1'b1;
      due_recs.push_back(r);
    end
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    opt_rec_t want;
    if (rst) begin
      due_recs.delete();
      phase      = PH_IDLE;
      bytes_left = '0;
      cur_kind   = '0;
      cur_length = '0;
      data_count = '0;
      value_sr   = '0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        parse_byte(in_mon.start_req, in_mon.area_len, in_mon.opt_byte);
      if (out_mon.valid && out_mon.ready) begin
        case (out_mon.rec_type)
          tcp_opt_pkg::REC_DATA:   data_seen++;
          tcp_opt_pkg::REC_OPTION: opts_seen++;
          default:                 ends_seen++;
        endcase
        if (due_recs.size() == 0) begin
          $error("record with nothing due: type %0d kind 0x%0h",
                 out_mon.rec_type, out_mon.opt_kind);
          fail_count++;
        end else begin
          want = due_recs.pop_front();
          compare_field("rec_type",   32'(want.rec_type),   32'(out_mon.rec_type));
          compare_field("opt_kind",   32'(want.kind),       32'(out_mon.opt_kind));
          compare_field("opt_length", 32'(want.length),     32'(out_mon.opt_length));
          compare_field("status",     32'(want.status),     32'(out_mon.status));
          compare_field("value_a",    want.value_a,         out_mon.value_a);
          compare_field("value_b",    want.value_b,         out_mon.value_b);
          compare_field("data_byte",  32'(want.data_byte),  32'(out_mon.data_byte));
          compare_field("data_index", 32'(want.data_index), 32'(out_mon.data_index));
          compare_field("last",       32'(want.last),       32'(out_mon.last));
        end
      end
    end
    records_due = due_recs.size();
  end

endmodule

// ===== tb/tb_tcp_option_parser.sv =====
// ----------------------------------------------------------------------------
// tb_tcp_option_parser
// Drives option areas into the parser and gives the verdict; all checking
// lives in the checker placed beside the block.
// ----------------------------------------------------------------------------
module tb_tcp_option_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_OPT      = 40;
  localparam int RANDOM_ITEMS = 230;
  localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
  localparam int STUCK_LIMIT  = 1000;  // cycles with no transfer at all
  localparam int TAIL_CYCLES  = 20;    // idle tail after the final drain

  typedef bit [7:0] byte_q_t[$];

  logic clk;
  logic rst;

  tcp_opt_in_if  in_if();
  tcp_opt_out_if out_if();

  int fail_count;
  int records_due;
  int data_seen;
  int opts_seen;
  int ends_seen;

  // stimulus knobs; sink_idle_en and hold_req also steer the receiver process
  bit src_idle_en;
  bit sink_idle_en;
  bit hold_req;

  int items_sent;
  int areas_sent;
  int stuck_cycles;

  tcp_option_parser #(.MAX_OPT_BYTES(MAX_OPT)) dut (
    .clk     (clk),
    .rst     (rst),
    .opt_in  (in_if),
    .rec_out (out_if)
  );

  tcp_opt_checker #(.MAX_OPT_BYTES(MAX_OPT)) u_chk (
    .clk         (clk),
    .rst         (rst),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .fail_count  (fail_count),
    .records_due (records_due),
    .data_seen   (data_seen),
    .opts_seen   (opts_seen),
    .ends_seen   (ends_seen)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog: a run that stops moving in both directions is a hang.
  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Receiver: ready changes at the falling edge. A hold request from the
  // stimulus side turns into a long stretch of ready low, counted here;
  // otherwise short random stalls while enabled.
  initial begin
    int stall_left;
    int hold_left;
    bit hold_taken;
    stall_left   = 0;
    hold_left    = 0;
    hold_taken   = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // One byte transfer. Called and returns at a falling edge; valid stays
  // high on return so back-to-back bytes need no extra assignment.
  task automatic send_byte(bit st, bit [5:0] alen, bit [7:0] b);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.start_req <= st;
    in_if.area_len  <= alen;
    in_if.opt_byte  <= b;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
    @(negedge clk);
  endtask

  // First byte carries start and the area length; the length field of the
  // following bytes is don't-care, so it gets noise.
  task automatic send_area(bit [5:0] alen, byte_q_t body);
    for (int i = 0; i < body.size(); i++)
      send_byte(i == 0, (i == 0) ? alen : 6'($urandom), body[i]);
    areas_sent++;
  endtask

  // Drop valid and wait until every predicted record has come out.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (records_due != 0);
  endtask

  // Mostly well-formed option lists with random payload, salted with the
  // malformed cases: wrong data lengths, length one, zero length, EOL and
  // stray bytes.
  function automatic byte_q_t build_options(int target);
    byte_q_t q;
    int      dlen;
    q = {};
    while (q.size() < target) begin
      dlen = 0;
      case ($urandom_range(0, 19))
        0, 1, 2: q.push_back(tcp_opt_pkg::KIND_NOP);
        3, 4, 5, 6: begin
          q.push_back(tcp_opt_pkg::KIND_MSS);
          q.push_back(8'd4);
          dlen = 2;
        end
        7, 8: begin
          q.push_back(tcp_opt_pkg::KIND_WSCALE);
          q.push_back(8'd3);
          dlen = 1;
        end
        9, 10, 11: begin
          q.push_back(tcp_opt_pkg::KIND_TS);
          q.push_back(8'd10);
          dlen = 8;
        end
        12, 13: begin
          // kind from 4 up (mostly unknown, may hit timestamp), arbitrary payload size
          q.push_back(8'($urandom_range(4, 255)));
          dlen = $urandom_range(0, 6);
          q.push_back(8'(dlen + 2));
        end
        14: begin
          // known kind with a data length that may be wrong
          case ($urandom_range(0, 2))
            0:       q.push_back(tcp_opt_pkg::KIND_MSS);
            1:       q.push_back(tcp_opt_pkg::KIND_WSCALE);
            default: q.push_back(tcp_opt_pkg::KIND_TS);
          endcase
          dlen = $urandom_range(0, 9);
          q.push_back(8'(dlen + 2));
        end
        15: begin
          q.push_back(8'($urandom_range(2, 255)));
          q.push_back(8'd1);
        end
        16: begin
          q.push_back(8'($urandom_range(2, 255)));
          q.push_back(8'd0);
        end
        17: q.push_back(tcp_opt_pkg::KIND_EOL);
        default: q.push_back(8'($urandom));
      endcase
      repeat (dlen) q.push_back(8'($urandom));
    end
    return q;
  endfunction

  initial begin
    byte_q_t  body;
    bit [5:0] alen;
    int       base_items;
    bit       hold_done;
    bit       drain_done;

    rst             = 1'b1;
    in_if.valid     = 1'b0;
    in_if.start_req = 1'b0;
    in_if.area_len  = '0;
    in_if.opt_byte  = '0;
    hold_req        = 1'b0;
    src_idle_en     = 1'b1;
    sink_idle_en    = 1'b1;
    hold_done       = 1'b0;
    drain_done      = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // empty area: only an end record
    send_area(6'd0, '{8'hFF});
    // oversized length gets clamped; EOL closes at once, trailing byte ignored
    send_area(6'd63, '{tcp_opt_pkg::KIND_EOL, 8'h00});
    // area left open at a kind byte, then abandoned by the next start
    send_area(6'd40, '{tcp_opt_pkg::KIND_TS});
    // length runs past the area end: truncated
    send_area(6'd2, '{8'd9, 8'd3});
    // zero length byte
    send_area(6'd3, '{8'd6, 8'd0});
    // NOP, MSS, timestamp, window scale, a length-one option, and a lone
    // kind byte as the last byte of the area
    send_area(6'd21, '{tcp_opt_pkg::KIND_NOP,
                       tcp_opt_pkg::KIND_MSS, 8'd4, 8'hFF, 8'hFF,
                       tcp_opt_pkg::KIND_TS, 8'd10, 8'h00, 8'h00, 8'h00, 8'h01,
                       8'hFF, 8'hFF, 8'hFF, 8'hFE,
                       tcp_opt_pkg::KIND_WSCALE, 8'd3, 8'h0E,
                       8'd7, 8'd1,
                       8'h22});

    // --- random part ---
    base_items = items_sent;
    while (items_sent - base_items < RANDOM_ITEMS) begin
      // receiver goes quiet for a long stretch while bytes keep coming
      if (!hold_done && items_sent - base_items >= 100) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      // sender stops until the block has nothing left to say
      if (!drain_done && items_sent - base_items >= 180) begin
        wait_drained();
        drain_done = 1'b1;
      end
      // last stretch runs at full rate on both sides
      if (items_sent - base_items >= 200) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end

      body = build_options(($urandom_range(0, 7) == 0) ? $urandom_range(20, 44)
                                                       : $urandom_range(1, 14));
      case ($urandom_range(0, 9))
        0:       alen = 6'($urandom_range(0, 63));
        1:       alen = (body.size() > 1) ? 6'(body.size() - 1) : 6'd1;
        default: alen = (body.size() > 63) ? 6'd63 : 6'(body.size());
      endcase
      send_area(alen, body);

      // stray bytes between areas (or into one left open)
      if ($urandom_range(0, 9) == 0)
        send_byte(1'b0, 6'($urandom), 8'($urandom));
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d option bytes in %0d areas; checked %0d data, %0d option, %0d end records.",
             items_sent, areas_sent, data_seen, opts_seen, ends_seen);
    $display("Covered EOL, NOP, MSS, window scale, timestamp, malformed lengths, restarts, stalls.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== tcp_option_parser.f =====
rtl/tcp_opt_pkg.sv
rtl/tcp_opt_ifs.sv
rtl/tcp_opt_front.sv
rtl/tcp_opt_queue.sv
rtl/tcp_opt_back.sv
rtl/tcp_option_parser.sv
tb/tcp_opt_checker.sv
tb/tb_tcp_option_parser.sv
